// File: hdl/hsv_mask_row_centroid_macros.svh
// Assertion macros shared by the HSV mask row-centroid RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef HSV_MASK_ROW_CENTROID_MACROS_SVH
`define HSV_MASK_ROW_CENTROID_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HMRC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HMRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hmrc_pkg.sv
// Package for the HSV mask row-centroid block: sizes, register indexes,
// the row job record, status structs and the back-end state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hmrc_pkg;

    // Region limits
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 4096;

    // Fixed field widths
    localparam int CHAN_W    = 8;
    localparam int ROWOFF_W  = 12;
    localparam int X_W       = 10;
    localparam int Y_W       = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Derived widths
    localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
    localparam int HITS_W  = COL_W;
    localparam int XSUM_W  = $clog2(MAX_COLUMNS * (MAX_COLUMNS - 1) / 2 + 1);
    localparam int MID_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int PY_W    = ((ROW_W > ROWOFF_W) ? ROW_W : ROWOFF_W) + 1;
    localparam int PTS_W   = $clog2(MAX_ROWS + 1);
    localparam int FXSUM_W = MID_W + PTS_W;
    localparam int FYSUM_W = PY_W + PTS_W;

    // Shared divider sizes
    localparam int DIV_N_W   = FYSUM_W;
    localparam int DIV_D_W   = (PTS_W > HITS_W) ? PTS_W : HITS_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // Row queue sizes
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET = 3'd6;

    // One finished row, handed from front to back
    typedef struct packed {
        logic [XSUM_W-1:0] x_sum;
        logic [HITS_W-1:0] hits;
        logic [PY_W-1:0]   py;
        logic              frame_end;
    } row_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROW_DIV,
        B_ACC,
        B_MEAN,
        B_MX_DIV,
        B_MY_DIV,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

// File: hdl/hmrc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on hmrc_pkg for operand widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module hmrc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [hmrc_pkg::DIV_N_W-1:0] dividend,
    input  wire logic [hmrc_pkg::DIV_D_W-1:0] divisor,
    output hmrc_pkg::div_status_t            status,
    output logic [hmrc_pkg::DIV_N_W-1:0]     quotient
);
    import hmrc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_D_W])
            begin
                rem_next = diff[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

// File: hdl/hmrc_queue.sv
// Short queue of finished row jobs between the pixel front and the divide back.
// Depends on hmrc_pkg for the job record, depth and status struct.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_mask_row_centroid_macros.svh"

module hmrc_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire hmrc_pkg::row_job_t   push_job,
    input  wire logic                 pop,
    output hmrc_pkg::row_job_t        head,
    output hmrc_pkg::queue_status_t   status
);
    import hmrc_pkg::*;

    row_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    `HMRC_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, !status.empty, "pop from empty row queue")
    `HMRC_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !status.full, "push into full row queue")
    `HMRC_ASSERT_NEXT(a_fill_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue fill did not grow on push")

endmodule

`default_nettype wire

// File: hdl/hmrc_front.sv
// Pixel front end: configuration registers, colour threshold, row accumulation.
// Depends on hmrc_pkg; pushes one job per finished row into hmrc_queue.
`timescale 1ns / 1ps
`default_nettype none

module hmrc_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [hmrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hmrc_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire logic                            pix_accept,
    input  wire logic [hmrc_pkg::CHAN_W-1:0]     hue,
    input  wire logic [hmrc_pkg::CHAN_W-1:0]     saturation,
    input  wire logic [hmrc_pkg::CHAN_W-1:0]     brightness,
    input  wire logic                            row_end,
    input  wire logic                            frame_end,
    output logic                                 push,
    output hmrc_pkg::row_job_t                   push_job
);
    import hmrc_pkg::*;

    logic [CHAN_W-1:0]   hue_low_reg,  hue_high_reg;
    logic [CHAN_W-1:0]   sat_low_reg,  sat_high_reg;
    logic [CHAN_W-1:0]   val_low_reg,  val_high_reg;
    logic [ROWOFF_W-1:0] row_offset_reg;

    logic [COL_W-1:0]    column_reg,  column_next;
    logic [XSUM_W-1:0]   x_sum_reg,   x_sum_next;
    logic [HITS_W-1:0]   hits_reg,    hits_next;
    logic [ROW_W-1:0]    row_idx_reg, row_idx_next;

    logic                in_range;
    logic                marked;
    logic [XSUM_W-1:0]   x_sum_upd;
    logic [HITS_W-1:0]   hits_upd;
    logic                closes_row;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg    <= '0;
            hue_high_reg   <= CHAN_MAX;
            sat_low_reg    <= '0;
            sat_high_reg   <= CHAN_MAX;
            val_low_reg    <= '0;
            val_high_reg   <= CHAN_MAX;
            row_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HUE_LOW:    hue_low_reg    <= cfg_data[CHAN_W-1:0];
                CFG_HUE_HIGH:   hue_high_reg   <= cfg_data[CHAN_W-1:0];
                CFG_SAT_LOW:    sat_low_reg    <= cfg_data[CHAN_W-1:0];
                CFG_SAT_HIGH:   sat_high_reg   <= cfg_data[CHAN_W-1:0];
                CFG_VAL_LOW:    val_low_reg    <= cfg_data[CHAN_W-1:0];
                CFG_VAL_HIGH:   val_high_reg   <= cfg_data[CHAN_W-1:0];
                CFG_ROW_OFFSET: row_offset_reg <= cfg_data[ROWOFF_W-1:0];
                default:        ;
            endcase
        end
    end

    // Classify the pixel against the three channel windows
    assign in_range = (hue >= hue_low_reg) && (hue <= hue_high_reg)
                   && (saturation >= sat_low_reg) && (saturation <= sat_high_reg)
                   && (brightness >= val_low_reg) && (brightness <= val_high_reg);
    assign marked     = in_range && (column_reg < COL_W'(MAX_COLUMNS));
    assign x_sum_upd  = marked ? x_sum_reg + XSUM_W'(column_reg) : x_sum_reg;
    assign hits_upd   = marked ? hits_reg + 1'b1 : hits_reg;
    assign closes_row = row_end || frame_end;

    // Hand the finished row to the back end
    assign push               = pix_accept && closes_row;
    assign push_job.x_sum     = x_sum_upd;
    assign push_job.hits      = hits_upd;
    assign push_job.py        = PY_W'(row_idx_reg) + PY_W'(row_offset_reg);
    assign push_job.frame_end = frame_end;

    // Advance column and row counters
    always_comb
    begin
        column_next  = column_reg;
        x_sum_next   = x_sum_reg;
        hits_next    = hits_reg;
        row_idx_next = row_idx_reg;
        if (pix_accept)
        begin
            if (closes_row)
            begin
                column_next = '0;
                x_sum_next  = '0;
                hits_next   = '0;
                if (frame_end)
                begin
                    row_idx_next = '0;
                end
                else if (row_idx_reg < ROW_W'(MAX_ROWS - 1))
                begin
                    row_idx_next = row_idx_reg + 1'b1;
                end
            end
            else
            begin
                x_sum_next = x_sum_upd;
                hits_next  = hits_upd;
                if (column_reg < COL_W'(MAX_COLUMNS))
                begin
                    column_next = column_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            x_sum_reg   <= '0;
            hits_reg    <= '0;
            row_idx_reg <= '0;
        end
        else
        begin
            column_reg  <= column_next;
            x_sum_reg   <= x_sum_next;
            hits_reg    <= hits_next;
            row_idx_reg <= row_idx_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/hmrc_back.sv
// Back end: row mean, frame accumulation, frame means and the output register.
// Depends on hmrc_pkg and hmrc_div; takes row jobs from hmrc_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_mask_row_centroid_macros.svh"

module hmrc_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire hmrc_pkg::row_job_t         head,
    input  wire hmrc_pkg::queue_status_t    q_status,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            point_valid,
    output logic [hmrc_pkg::X_W-1:0]        mid_x,
    output logic [hmrc_pkg::Y_W-1:0]        point_y,
    output logic                            frame_done,
    output logic                            mean_valid,
    output logic [hmrc_pkg::X_W-1:0]        mean_x,
    output logic [hmrc_pkg::Y_W-1:0]        mean_y
);
    import hmrc_pkg::*;

    back_state_t         state_reg, state_next;
    row_job_t            job_reg, job_next;
    logic [MID_W-1:0]    mid_reg, mid_next;
    logic [FXSUM_W-1:0]  fx_sum_reg, fx_sum_next;
    logic [FYSUM_W-1:0]  fy_sum_reg, fy_sum_next;
    logic [PTS_W-1:0]    pts_reg, pts_next;
    logic [X_W-1:0]      mean_x_reg, mean_x_next;
    logic [Y_W-1:0]      mean_y_reg, mean_y_next;

    logic                out_valid_reg, out_valid_next;
    logic                point_valid_reg, frame_done_reg, mean_valid_reg;
    logic [X_W-1:0]      mid_x_reg, mean_x_out_reg;
    logic [Y_W-1:0]      point_y_reg, mean_y_out_reg;

    logic                div_start;
    logic [DIV_N_W-1:0]  div_dividend;
    logic [DIV_D_W-1:0]  div_divisor;
    div_status_t         div_status;
    logic [DIV_N_W-1:0]  div_quotient;

    logic                out_free;
    logic                out_load;

    hmrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (head.hits != '0) ? B_ROW_DIV : B_ACC;
                end
            end
            B_ROW_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = B_ACC;
                end
            end
            B_ACC:
            begin
                state_next = B_MEAN;
            end
            B_MEAN:
            begin
                state_next = (job_reg.frame_end && pts_reg != '0) ? B_MX_DIV : B_EMIT;
            end
            B_MX_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = B_MY_DIV;
                end
            end
            B_MY_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Datapath controls and next values
    always_comb
    begin
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_N_W'(head.x_sum);
        div_divisor  = DIV_D_W'(head.hits);
        out_load     = 1'b0;
        job_next     = job_reg;
        mid_next     = mid_reg;
        fx_sum_next  = fx_sum_reg;
        fy_sum_next  = fy_sum_reg;
        pts_next     = pts_reg;
        mean_x_next  = mean_x_reg;
        mean_y_next  = mean_y_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop       = 1'b1;
                    job_next  = head;
                    mid_next  = '0;
                    div_start = (head.hits != '0);
                end
            end
            B_ROW_DIV:
            begin
                if (div_status.done)
                begin
                    mid_next = MID_W'(div_quotient);
                end
            end
            B_ACC:
            begin
                mean_x_next = '0;
                mean_y_next = '0;
                if (job_reg.hits != '0 && pts_reg < PTS_W'(MAX_ROWS))
                begin
                    fx_sum_next = fx_sum_reg + FXSUM_W'(mid_reg);
                    fy_sum_next = fy_sum_reg + FYSUM_W'(job_reg.py);
                    pts_next    = pts_reg + 1'b1;
                end
            end
            B_MEAN:
            begin
                div_dividend = DIV_N_W'(fx_sum_reg);
                div_divisor  = DIV_D_W'(pts_reg);
                div_start    = job_reg.frame_end && (pts_reg != '0);
            end
            B_MX_DIV:
            begin
                div_dividend = DIV_N_W'(fy_sum_reg);
                div_divisor  = DIV_D_W'(pts_reg);
                if (div_status.done)
                begin
                    mean_x_next = X_W'(div_quotient);
                    div_start   = 1'b1;
                end
            end
            B_MY_DIV:
            begin
                if (div_status.done)
                begin
                    mean_y_next = Y_W'(div_quotient);
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (job_reg.frame_end)
                    begin
                        fx_sum_next = '0;
                        fy_sum_next = '0;
                        pts_next    = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Hold or drop the result in the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fx_sum_reg    <= '0;
            fy_sum_reg    <= '0;
            pts_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fx_sum_reg    <= fx_sum_next;
            fy_sum_reg    <= fy_sum_next;
            pts_reg       <= pts_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        mid_reg    <= mid_next;
        mean_x_reg <= mean_x_next;
        mean_y_reg <= mean_y_next;
    end

    // Output payload, loaded once per result
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            point_valid_reg <= (job_reg.hits != '0);
            mid_x_reg       <= X_W'(mid_reg);
            point_y_reg     <= Y_W'(job_reg.py);
            frame_done_reg  <= job_reg.frame_end;
            mean_valid_reg  <= job_reg.frame_end && (pts_reg != '0);
            mean_x_out_reg  <= mean_x_reg;
            mean_y_out_reg  <= mean_y_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_valid = point_valid_reg;
    assign mid_x       = mid_x_reg;
    assign point_y     = point_y_reg;
    assign frame_done  = frame_done_reg;
    assign mean_valid  = mean_valid_reg;
    assign mean_x      = mean_x_out_reg;
    assign mean_y      = mean_y_out_reg;

    `HMRC_ASSERT_SAME(a_start_idle_div, clk, rst_n, div_start, !div_status.busy, "divider started while busy")
    `HMRC_ASSERT_SAME(a_done_in_wait, clk, rst_n, div_status.done, (state_reg == B_ROW_DIV) || (state_reg == B_MX_DIV) || (state_reg == B_MY_DIV), "divider finished outside a wait state")
    `HMRC_ASSERT_NEXT(a_load_back_idle, clk, rst_n, out_load, out_valid_reg && (state_reg == B_IDLE), "result load did not return to idle")

endmodule

`default_nettype wire

// File: hdl/hsv_mask_row_centroid.sv
// Top level of the HSV mask row-centroid block: wires front, row queue and back.
// Depends on hmrc_pkg, hmrc_front, hmrc_queue and hmrc_back.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  pixel   | in_valid, in_stall, hue .. frame_end       | in (stall out)
//  result  | out_valid, out_stall, point_valid .. mean_y | out (stall in)
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | in (ready out)
//
// Pixels are taken one per cycle; in_stall rises only while the four-entry row
// queue is full. Each row with hits costs the back end one pass of the 26-step
// shared divider; a frame-closing row with points adds two more divisions.
// A result waits in the output register under out_stall while the back end goes
// on with the next row. Reset clears counters, sums and the queue; the channel
// bounds reset to the full range and the row offset to zero.
`timescale 1ns / 1ps
`default_nettype none

module hsv_mask_row_centroid (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hmrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hmrc_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [hmrc_pkg::CHAN_W-1:0]     hue,
    input  wire logic [hmrc_pkg::CHAN_W-1:0]     saturation,
    input  wire logic [hmrc_pkg::CHAN_W-1:0]     brightness,
    input  wire logic                            row_end,
    input  wire logic                            frame_end,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 point_valid,
    output logic [hmrc_pkg::X_W-1:0]             mid_x,
    output logic [hmrc_pkg::Y_W-1:0]             point_y,
    output logic                                 frame_done,
    output logic                                 mean_valid,
    output logic [hmrc_pkg::X_W-1:0]             mean_x,
    output logic [hmrc_pkg::Y_W-1:0]             mean_y
);
    import hmrc_pkg::*;

    logic          pix_accept;
    logic          push;
    row_job_t      push_job;
    logic          pop;
    row_job_t      head;
    queue_status_t q_status;

    // Registers take a write in any cycle
    assign cfg_ready  = 1'b1;
    assign in_stall   = q_status.full;
    assign pix_accept = in_valid && !in_stall;

    hmrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_accept (pix_accept),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .row_end    (row_end),
        .frame_end  (frame_end),
        .push       (push),
        .push_job   (push_job)
    );

    hmrc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    hmrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_valid (point_valid),
        .mid_x       (mid_x),
        .point_y     (point_y),
        .frame_done  (frame_done),
        .mean_valid  (mean_valid),
        .mean_x      (mean_x),
        .mean_y      (mean_y)
    );

endmodule

`default_nettype wire
